>>> hw/rtl/sjf_pkg.sv
// ----------------------------------------------------------------------------
// sjf_pkg
// Shared widths and types for the non-preemptive shortest-job-first orderer.
// ----------------------------------------------------------------------------
package sjf_pkg;

	// Job store depth
	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);

	// Field widths
	localparam int BURST_W  = 10;
	localparam int ARR_W    = 16;
	localparam int TIME_W   = 16;
	localparam int JIDX_W   = 6;

	// One stored job as it sits in the job memory
	typedef struct packed {
		logic [BURST_W-1:0] burst;
		logic [ARR_W-1:0]   arrival;
	} job_entry_t;

	localparam int ENTRY_W = $bits(job_entry_t);

endpackage

>>> hw/rtl/sjf_job_if.sv
// ----------------------------------------------------------------------------
// sjf_job_if
// Job load channel: one job per transfer, last_job closes the batch.
// ----------------------------------------------------------------------------
interface sjf_job_if;

	logic                        valid;
	logic                        ready;
	logic [sjf_pkg::BURST_W-1:0] burst_time;
	logic [sjf_pkg::ARR_W-1:0]   arrival_time;
	logic                        last_job;

	modport source (output valid, output burst_time, output arrival_time,
		output last_job, input ready);
	modport sink (input valid, input burst_time, input arrival_time,
		input last_job, output ready);

endinterface

>>> hw/rtl/sjf_result_if.sv
// ----------------------------------------------------------------------------
// sjf_result_if
// Schedule channel: one scheduled job per transfer.
// ----------------------------------------------------------------------------
interface sjf_result_if;

	logic                        valid;
	logic                        ready;
	logic [sjf_pkg::JIDX_W-1:0]  job_index;
	logic [sjf_pkg::BURST_W-1:0] job_burst;
	logic [sjf_pkg::ARR_W-1:0]   job_arrival;
	logic [sjf_pkg::TIME_W-1:0]  finish_time;
	logic                        end_of_order;

	modport source (output valid, output job_index, output job_burst,
		output job_arrival, output finish_time, output end_of_order, input ready);
	modport sink (input valid, input job_index, input job_burst,
		input job_arrival, input finish_time, input end_of_order, output ready);

endinterface

>>> hw/rtl/sjf_nonpreemptive_order.sv
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_order
// Loads a batch of jobs into the job memory, then emits the non-preemptive
// shortest-job-first order, one scheduled job per output transfer.
// ----------------------------------------------------------------------------
// Load: one job per cycle while in the load state; a batch of n jobs then
// yields one result per stored job, and at most MAX_JOBS jobs are stored.
// Each selection makes one memory read per stored job, the first reading only job zero.
// The output register lets a result wait while the next selection runs.
// Reset clears the job count, running time, chosen flags and the output
// valid; the job memory itself is not cleared.
// ----------------------------------------------------------------------------
module sjf_nonpreemptive_order (
	input  logic          clk,
	input  logic          arst_n,
	sjf_job_if.sink       jobs,
	sjf_result_if.source  schedule
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [sjf_pkg::CNT_W-1:0] MAX_CNT = sjf_pkg::CNT_W'(sjf_pkg::MAX_JOBS);

	logic [1:0]                     state_q;
	logic [sjf_pkg::CNT_W-1:0]      count_q;
	logic [sjf_pkg::CNT_W-1:0]      rank_q;
	logic [sjf_pkg::CNT_W-1:0]      iss_q;
	logic [sjf_pkg::TIME_W-1:0]     run_q;
	logic [sjf_pkg::MAX_JOBS-1:0]   chosen_q;
	logic                           drain_q;
	logic                           first_q;

	logic                           vld_s1;
	logic [sjf_pkg::IDX_W-1:0]      idx_s1;

	// Best candidates of the current scan
	logic                           el_found_q;
	logic [sjf_pkg::IDX_W-1:0]      el_idx_q;
	logic [sjf_pkg::BURST_W-1:0]    el_burst_q;
	logic [sjf_pkg::ARR_W-1:0]      el_arr_q;
	logic                           rem_found_q;
	logic [sjf_pkg::IDX_W-1:0]      rem_idx_q;
	logic [sjf_pkg::BURST_W-1:0]    rem_burst_q;
	logic [sjf_pkg::ARR_W-1:0]      rem_arr_q;

	// Output register
	logic                           out_vld_q;
	logic [sjf_pkg::JIDX_W-1:0]     out_idx_q;
	logic [sjf_pkg::BURST_W-1:0]    out_burst_q;
	logic [sjf_pkg::ARR_W-1:0]      out_arr_q;
	logic [sjf_pkg::TIME_W-1:0]     out_fin_q;
	logic                           out_end_q;

	logic                           load_xfer;
	logic                           store_we;
	sjf_pkg::job_entry_t            wr_entry;
	sjf_pkg::job_entry_t            rd_entry;
	logic [sjf_pkg::CNT_W-1:0]      scan_len;
	logic                           issue;
	logic                           scan_last;
	logic                           el_take;
	logic                           rem_take;
	logic                           use_el;
	logic [sjf_pkg::IDX_W-1:0]      sel_idx;
	logic [sjf_pkg::BURST_W-1:0]    sel_burst;
	logic [sjf_pkg::ARR_W-1:0]      sel_arr;
	logic                           emit;
	logic                           batch_end;

	// Load handshake and job memory write
	assign jobs.ready = (state_q == ST_LOAD);
	assign load_xfer  = jobs.valid && jobs.ready;
	assign store_we   = load_xfer && (count_q < MAX_CNT);
	assign wr_entry   = '{burst: jobs.burst_time, arrival: jobs.arrival_time};

	sjf_ram #(
		.WIDTH (sjf_pkg::ENTRY_W),
		.DEPTH (sjf_pkg::MAX_JOBS)
	) u_job_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[sjf_pkg::IDX_W-1:0]),
		.wdata (wr_entry),
		.raddr (iss_q[sjf_pkg::IDX_W-1:0]),
		.rdata (rd_entry)
	);

	// Scan control: the first selection only looks at job zero
	assign scan_len  = first_q ? sjf_pkg::CNT_W'(1) : count_q;
	assign issue     = (state_q == ST_SCAN) && (iss_q < scan_len);
	assign scan_last = vld_s1 && (sjf_pkg::CNT_W'(idx_s1) == scan_len - 1'b1);

	// Compare the returning entry against both running bests
	always_comb begin
		el_take  = 1'b0;
		rem_take = 1'b0;
		if (vld_s1 && !chosen_q[idx_s1]) begin
			el_take = (first_q || (rd_entry.arrival <= run_q)) &&
				(!el_found_q || (rd_entry.burst < el_burst_q));
			rem_take = !rem_found_q || (rd_entry.burst < rem_burst_q) ||
				((rd_entry.burst == rem_burst_q) && (rd_entry.arrival < rem_arr_q));
		end
	end

	// Pick: arrived job unless none arrived or the order is already draining
	assign use_el    = el_found_q && !drain_q;
	assign sel_idx   = use_el ? el_idx_q   : rem_idx_q;
	assign sel_burst = use_el ? el_burst_q : rem_burst_q;
	assign sel_arr   = use_el ? el_arr_q   : rem_arr_q;
	assign emit      = (state_q == ST_EMIT) && (!out_vld_q || schedule.ready);
	assign batch_end = (rank_q == count_q - 1'b1);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			rank_q      <= '0;
			iss_q       <= '0;
			run_q       <= '0;
			chosen_q    <= '0;
			drain_q     <= 1'b0;
			first_q     <= 1'b1;
			vld_s1      <= 1'b0;
			el_found_q  <= 1'b0;
			rem_found_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			// Raise the output valid on emit, drop it once transferred
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (schedule.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_LOAD: begin
					if (load_xfer) begin
						if (store_we) begin
							count_q <= count_q + 1'b1;
						end
						if (jobs.last_job) begin
							state_q     <= ST_SCAN;
							iss_q       <= '0;
							el_found_q  <= 1'b0;
							rem_found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					// Advance the read address, one stored job per cycle
					vld_s1 <= issue;
					if (issue) begin
						iss_q <= iss_q + 1'b1;
					end
					if (el_take) begin
						el_found_q <= 1'b1;
					end
					if (rem_take) begin
						rem_found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						iss_q       <= '0;
						el_found_q  <= 1'b0;
						rem_found_q <= 1'b0;
						if (batch_end) begin
							// Clear for the next batch
							state_q  <= ST_LOAD;
							count_q  <= '0;
							rank_q   <= '0;
							run_q    <= '0;
							chosen_q <= '0;
							drain_q  <= 1'b0;
							first_q  <= 1'b1;
						end else begin
							chosen_q[sel_idx] <= 1'b1;
							run_q             <= run_q + sjf_pkg::TIME_W'(sel_burst);
							if (!use_el) begin
								drain_q <= 1'b1;
							end
							first_q <= 1'b0;
							rank_q  <= rank_q + 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Scan pipeline and candidate payloads
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= iss_q[sjf_pkg::IDX_W-1:0];
		end
		if (el_take) begin
			el_idx_q   <= idx_s1;
			el_burst_q <= rd_entry.burst;
			el_arr_q   <= rd_entry.arrival;
		end
		if (rem_take) begin
			rem_idx_q   <= idx_s1;
			rem_burst_q <= rd_entry.burst;
			rem_arr_q   <= rd_entry.arrival;
		end
		// Hold the result until transferred
		if (emit) begin
			out_idx_q   <= sjf_pkg::JIDX_W'(sel_idx);
			out_burst_q <= sel_burst;
			out_arr_q   <= sel_arr;
			out_fin_q   <= run_q + sjf_pkg::TIME_W'(sel_burst);
			out_end_q   <= batch_end;
		end
	end

	assign schedule.valid        = out_vld_q;
	assign schedule.job_index    = out_idx_q;
	assign schedule.job_burst    = out_burst_q;
	assign schedule.job_arrival  = out_arr_q;
	assign schedule.finish_time  = out_fin_q;
	assign schedule.end_of_order = out_end_q;

endmodule

>>> hw/rtl/sjf_ram.sv
// ----------------------------------------------------------------------------
// sjf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sjf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
